// ----- hdl/eadsr_pkg.sv -----
// ----------------------------------------------------------------------------
// eadsr_pkg
// Shared types and constants for the exponential ADSR envelope block.
// ----------------------------------------------------------------------------
`default_nettype none

package eadsr_pkg;

  // fixed-point format of the level: 1 << FRAC_BITS is 1.0
  localparam int FRAC_BITS = 24;
  localparam int POLE_W    = FRAC_BITS;
  localparam int LEVEL_W   = FRAC_BITS + 1;
  localparam int PROD_W    = 2 * LEVEL_W;

  localparam logic [LEVEL_W-1:0] ONE_FX    = LEVEL_W'(64'd1 << FRAC_BITS);
  localparam logic [PROD_W-1:0]  HALF_FX   = PROD_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic [LEVEL_W-1:0] THRESH_FX = LEVEL_W'(((64'd1 << FRAC_BITS) * 99) / 100);

  // stream words
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 32;

  // register port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [POLE_W-1:0]  ATTACK_POLE_RST   = POLE_W'(16771392);
  localparam logic [POLE_W-1:0]  DECAY_POLE_RST    = POLE_W'(16773721);
  localparam logic [POLE_W-1:0]  RELEASE_POLE_RST  = POLE_W'(16776051);
  localparam logic [LEVEL_W-1:0] SUSTAIN_LEVEL_RST = LEVEL_W'(8388608);

  typedef enum logic [1:0] {
    REG_ATTACK_POLE   = 2'd0,
    REG_DECAY_POLE    = 2'd1,
    REG_RELEASE_POLE  = 2'd2,
    REG_SUSTAIN_LEVEL = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_ATTACK  = 2'd1,
    PH_DECAY   = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  typedef struct packed {
    logic [POLE_W-1:0]  attack_pole;
    logic [POLE_W-1:0]  decay_pole;
    logic [POLE_W-1:0]  release_pole;
    logic [LEVEL_W-1:0] sustain_level;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic [LEVEL_W-1:0] level;
  } env_state_t;

endpackage

`default_nettype wire

// ----- hdl/eadsr_regs.sv -----
// ----------------------------------------------------------------------------
// eadsr_regs
// APB register file holding the filter poles and the sustain level.
// ----------------------------------------------------------------------------
`default_nettype none

module eadsr_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [eadsr_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [eadsr_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [eadsr_pkg::APB_DATA_W-1:0] prdata,
  output logic                                  pready,
  output eadsr_pkg::cfg_t                       cfg
);

  eadsr_pkg::reg_index_t idx;
  logic                  wr_en;

  assign pready = 1'b1;
  assign idx    = eadsr_pkg::reg_index_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_pole   <= eadsr_pkg::ATTACK_POLE_RST;
      cfg.decay_pole    <= eadsr_pkg::DECAY_POLE_RST;
      cfg.release_pole  <= eadsr_pkg::RELEASE_POLE_RST;
      cfg.sustain_level <= eadsr_pkg::SUSTAIN_LEVEL_RST;
    end else if (wr_en) begin
      unique case (idx)
        eadsr_pkg::REG_ATTACK_POLE:   cfg.attack_pole   <= pwdata[eadsr_pkg::POLE_W-1:0];
        eadsr_pkg::REG_DECAY_POLE:    cfg.decay_pole    <= pwdata[eadsr_pkg::POLE_W-1:0];
        eadsr_pkg::REG_RELEASE_POLE:  cfg.release_pole  <= pwdata[eadsr_pkg::POLE_W-1:0];
        eadsr_pkg::REG_SUSTAIN_LEVEL: cfg.sustain_level <= pwdata[eadsr_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      eadsr_pkg::REG_ATTACK_POLE:   prdata = eadsr_pkg::APB_DATA_W'(cfg.attack_pole);
      eadsr_pkg::REG_DECAY_POLE:    prdata = eadsr_pkg::APB_DATA_W'(cfg.decay_pole);
      eadsr_pkg::REG_RELEASE_POLE:  prdata = eadsr_pkg::APB_DATA_W'(cfg.release_pole);
      eadsr_pkg::REG_SUSTAIN_LEVEL: prdata = eadsr_pkg::APB_DATA_W'(cfg.sustain_level);
      default:                      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/eadsr_step.sv -----
// ----------------------------------------------------------------------------
// eadsr_step
// One envelope step: phase update, one-pole filter move, decay handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module eadsr_step (
  input  wire logic                 gate,
  input  wire eadsr_pkg::env_state_t cur,
  input  wire eadsr_pkg::cfg_t      cfg,
  output eadsr_pkg::env_state_t     nxt
);

  localparam int LW = eadsr_pkg::LEVEL_W;

  eadsr_pkg::phase_t     ph1;
  logic [LW-1:0]         lvl;
  logic [LW-1:0]         target;
  logic [LW-1:0]         sustain_sat;
  logic [eadsr_pkg::POLE_W-1:0] pole;
  logic [LW-1:0]         coeff;
  logic                  up;
  logic [LW-1:0]         mag;
  logic [eadsr_pkg::PROD_W-1:0] prod;
  logic [eadsr_pkg::PROD_W-1:0] rnd;
  logic [LW-1:0]         step;
  logic [LW:0]           sum;
  logic [LW-1:0]         lvl_up;
  logic [LW-1:0]         lvl_dn;
  logic [LW-1:0]         lvl_new;

  assign lvl = (cur.level > eadsr_pkg::ONE_FX) ? eadsr_pkg::ONE_FX : cur.level;
  assign sustain_sat = (cfg.sustain_level > eadsr_pkg::ONE_FX) ?
                       eadsr_pkg::ONE_FX : cfg.sustain_level;

  // phase as decided before the filter move
  always_comb begin
    if (!gate)
      ph1 = eadsr_pkg::PH_RELEASE;
    else if (cur.phase != eadsr_pkg::PH_DECAY)
      ph1 = eadsr_pkg::PH_ATTACK;
    else
      ph1 = eadsr_pkg::PH_DECAY;
  end

  always_comb begin
    case (ph1)
      eadsr_pkg::PH_ATTACK: begin
        target = eadsr_pkg::ONE_FX;
        pole   = cfg.attack_pole;
      end
      eadsr_pkg::PH_DECAY: begin
        target = sustain_sat;
        pole   = cfg.decay_pole;
      end
      default: begin
        target = '0;
        pole   = cfg.release_pole;
      end
    endcase
  end

  // pole is below 1.0 by width, so the coefficient is never negative
  assign coeff = eadsr_pkg::ONE_FX - LW'(pole);
  assign up    = (target >= lvl);
  assign mag   = up ? (target - lvl) : (lvl - target);
  assign prod  = eadsr_pkg::PROD_W'(coeff) * eadsr_pkg::PROD_W'(mag);
  assign rnd   = prod + eadsr_pkg::HALF_FX;
  assign step  = rnd[eadsr_pkg::FRAC_BITS +: LW];

  assign sum    = {1'b0, lvl} + {1'b0, step};
  assign lvl_up = (sum > (LW+1)'(eadsr_pkg::ONE_FX)) ? eadsr_pkg::ONE_FX : sum[LW-1:0];
  assign lvl_dn = (step >= lvl) ? '0 : (lvl - step);

  always_comb begin
    if (ph1 == eadsr_pkg::PH_IDLE)
      lvl_new = lvl;
    else
      lvl_new = up ? lvl_up : lvl_dn;
  end

  always_comb begin
    nxt.level = lvl_new;
    if (ph1 == eadsr_pkg::PH_ATTACK && lvl_new > eadsr_pkg::THRESH_FX)
      nxt.phase = eadsr_pkg::PH_DECAY;
    else
      nxt.phase = ph1;
  end

endmodule

`default_nettype wire

// ----- hdl/exponential_adsr_envelope.sv -----
// ----------------------------------------------------------------------------
// exponential_adsr_envelope
// Exponential ADSR envelope: one gate bit in, one level and phase out per word.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one word per audio sample, s_tdata[0] is the gate
//   (1 note held, 0 released). Output stream m_*: one word per input word,
//   level in m_tdata[24:0] (1 << 24 is 1.0), phase in m_tdata[26:25]
//   (idle, attack, decay, release).
//   An accepted word is held in the input register, then stepped into the state and
//   output registers once the output slot is free or draining. Throughput: one word per
//   cycle with m_tready high; the state loop (level, phase) is one multiply-add-saturate.
//   Stall: the input register and the output register hold one word each;
//   with m_tready low, one more word is taken, then s_tready drops.
//   Reset (rst, synchronous): phase idle, level 0, both registers empty,
//   registers at their default poles and sustain level.
//   Registers (APB, byte address 4*i): attack_pole, decay_pole,
//   release_pole, sustain_level. Write them only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module exponential_adsr_envelope (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // stream in
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [eadsr_pkg::S_TDATA_W-1:0]  s_tdata,   // [0] gate, rest zero
  // stream out
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [eadsr_pkg::M_TDATA_W-1:0]  m_tdata,   // [24:0] level, [26:25] phase_out
  // register port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [eadsr_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [eadsr_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [eadsr_pkg::APB_DATA_W-1:0] prdata,
  output logic                                  pready
);

  localparam int LW = eadsr_pkg::LEVEL_W;

  eadsr_pkg::cfg_t       cfg;
  eadsr_pkg::env_state_t state;
  eadsr_pkg::env_state_t state_next;

  logic in_valid;
  logic in_gate;
  logic advance;

  eadsr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // the step from the held gate word and the current state
  eadsr_step u_step (
    .gate (in_gate),
    .cur  (state),
    .cfg  (cfg),
    .nxt  (state_next)
  );

  // input word moves to the output register when that slot is free or draining
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_gate <= s_tdata[0];
    end
  end

  // envelope state: moves once per word
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase <= eadsr_pkg::PH_IDLE;
      state.level <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= eadsr_pkg::M_TDATA_W'({state_next.phase, state_next.level});
    end
  end

  // level stays within [0, 1.0]
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    state.level <= eadsr_pkg::ONE_FX)
    else $error("envelope level above full scale");

  // after any step the phase has left idle
  a_no_idle: assert property (@(posedge clk) disable iff (rst)
    advance |=> state.phase != eadsr_pkg::PH_IDLE)
    else $error("phase idle after a step");

  // a held input word is never dropped while the output stalls
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_gate))
    else $error("input word lost during stall");

  // state only moves when a word is stepped
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("envelope state moved without a word");

  // the shown level matches the state it came from
  a_out_match: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tdata[LW-1:0] == state.level)
    else $error("output level differs from state");

endmodule

`default_nettype wire
